// ----- rtl/svoel_pkg.sv -----
`default_nettype none
// ============================================================================
// svoel_pkg
// Shared types, widths and helpers of the synth voice core.
// ============================================================================
package svoel_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int STEP_W  = 31;
	localparam int GLIDE_W = 16;

	// Serial multiplier: signed multiplicand, unsigned multiplier.
	localparam int MCAND_W = 32;
	localparam int MIER_W  = 17;
	localparam int PROD_W  = MCAND_W + MIER_W;
	localparam int CNT_W   = $clog2(MIER_W + 1);

	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic                      start;
		logic signed [MCAND_W-1:0] mcand;
		logic [MIER_W-1:0]         mier;
	} mul_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		prod_t product;
	} mul_rsp_t;

	typedef struct packed {
		logic [15:0] attack;
		logic [15:0] decay;
		logic [1:0]  wave;
		logic        sub_en;
		logic [15:0] cutoff;
		logic [15:0] reso;
	} cfg_t;

	// Division by 2^sh that truncates toward zero.
	function automatic prod_t tdiv(input prod_t p, input int unsigned sh);
		prod_t one;
		prod_t bias;
		one  = prod_t'(1);
		bias = p[PROD_W-1] ? ((one <<< sh) - one) : prod_t'(0);
		return (p + bias) >>> sh;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/svoel_if.sv -----
`default_nettype none
// ============================================================================
// svoel_if
// Request channel and sample channel of the synth voice core.
// ============================================================================
interface svoel_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [svoel_pkg::STEP_W-1:0]  note_step;
	logic [svoel_pkg::GLIDE_W-1:0] glide_rate;
	logic                          retrigger;

	modport source(output valid, action, note_step, glide_rate, retrigger, input ready);
	modport sink(input valid, action, note_step, glide_rate, retrigger, output ready);
endinterface

interface svoel_audio_if #(parameter int SAMPLE_BITS = svoel_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/svoel_mul.sv -----
`default_nettype none
// ============================================================================
// svoel_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
module svoel_mul (
	input  wire                   clk,
	input  wire                   arst_n,
	input  svoel_pkg::mul_req_t   req,
	output svoel_pkg::mul_rsp_t   rsp
);

	logic [svoel_pkg::CNT_W-1:0]  cnt_q;
	logic                         done_q;
	svoel_pkg::prod_t             mc_q;
	svoel_pkg::prod_t             acc_q;
	logic [svoel_pkg::MIER_W-1:0] mr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= svoel_pkg::CNT_W'(svoel_pkg::MIER_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == svoel_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The multiplicand moves left while the multiplier moves right.
	always_ff @(posedge clk) begin
		if (req.start) begin
			mc_q  <= svoel_pkg::prod_t'(req.mcand);
			mr_q  <= req.mier;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (mr_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q <<< 1;
			mr_q <= mr_q >> 1;
		end
	end

	assign rsp.busy    = (cnt_q != '0);
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
`default_nettype wire

// ----- rtl/svoel_cfg.sv -----
`default_nettype none
// ============================================================================
// svoel_cfg
// APB register file holding the voice settings.
// ============================================================================
module svoel_cfg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [4:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output svoel_pkg::cfg_t   cfg
);

	typedef enum logic [2:0] {
		REG_ATTACK = 3'd0,
		REG_DECAY  = 3'd1,
		REG_WAVE   = 3'd2,
		REG_SUB    = 3'd3,
		REG_CUTOFF = 3'd4,
		REG_RESO   = 3'd5
	} reg_idx_t;

	svoel_pkg::cfg_t cfg_q;
	logic            wr_en;
	reg_idx_t        idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack <= 16'd655;
			cfg_q.decay  <= 16'd65470;
			cfg_q.wave   <= 2'd1;
			cfg_q.sub_en <= 1'b0;
			cfg_q.cutoff <= 16'd16384;
			cfg_q.reso   <= 16'd0;
		end else if (wr_en) begin
			case (idx)
				REG_ATTACK: cfg_q.attack <= pwdata[15:0];
				REG_DECAY:  cfg_q.decay  <= pwdata[15:0];
				REG_WAVE:   cfg_q.wave   <= pwdata[1:0];
				REG_SUB:    cfg_q.sub_en <= pwdata[0];
				REG_CUTOFF: cfg_q.cutoff <= pwdata[15:0];
				REG_RESO:   cfg_q.reso   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ATTACK: prdata = {16'd0, cfg_q.attack};
			REG_DECAY:  prdata = {16'd0, cfg_q.decay};
			REG_WAVE:   prdata = {30'd0, cfg_q.wave};
			REG_SUB:    prdata = {31'd0, cfg_q.sub_en};
			REG_CUTOFF: prdata = {16'd0, cfg_q.cutoff};
			REG_RESO:   prdata = {16'd0, cfg_q.reso};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/synth_voice_osc_env_ladder_core.sv -----
`default_nettype none
// ============================================================================
// synth_voice_osc_env_ladder_core
// One synth voice: gliding oscillator with sub octave, attack/decay envelope
// and a resonant three-pole lowpass, all products on one serial multiplier.
// ============================================================================
//
//  channel  dir  handshake        payload
//  cmd      in   valid / ready    action, note_step, glide_rate, retrigger
//  audio    out  valid / ready    sample
//  apb      in   psel / penable   paddr, pwdata, prdata (pready always high)
//
// A note event is handled in the idle state. A tick runs fifteen products through the
// bit-serial multiplier, each as a load, a step for each multiplier bit and a
// write back, and then emits the sample into the output
// register.
// A new request is taken while a sample waits; a finished tick holds in its
// last step until the output register is free.
// Reset clears the voice state and loads the register defaults.
//
module synth_voice_osc_env_ladder_core #(
	parameter int PHASE_BITS  = svoel_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = svoel_pkg::SAMPLE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	svoel_cmd_if.sink   cmd,
	svoel_audio_if.source audio,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int STEP_W = svoel_pkg::STEP_W;
	localparam int SUM_W  = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
	localparam int UP     = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
	localparam int DN     = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam int OW     = 18 + UP + 1;
	localparam logic signed [OW-1:0] DN_MASK = OW'((1 <<< DN) - 1);
	localparam logic signed [OW-1:0] SMAX = OW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [OW-1:0] SMIN = -SMAX - OW'(1);

	localparam logic [1:0] WAVE_SAW    = 2'd1;
	localparam logic [1:0] WAVE_SQUARE = 2'd2;
	localparam logic [1:0] WAVE_MIX    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		OP_GLIDE, OP_DECAY, OP_SUB, OP_ENV, OP_FB, OP_HP, OP_COMP, OP_SQ,
		OP_SHAPE, OP_P0A, OP_P0B, OP_P1A, OP_P1B, OP_P2A, OP_P2B
	} op_t;

	svoel_pkg::cfg_t     cfg;
	svoel_pkg::mul_req_t mreq;
	svoel_pkg::mul_rsp_t mrsp;

	state_t                  state_q;
	op_t                     op_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [STEP_W-1:0]       cur_q;
	logic [STEP_W-1:0]       tgt_q;
	logic [15:0]             glide_q;
	logic [16:0]             env_q;
	logic                    att_q;
	logic                    sub_q;
	logic signed [17:0]      pole_q [3];
	logic signed [17:0]      hps_q;
	logic signed [17:0]      lfb_q;
	logic                    out_v_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// Per-tick intermediates.
	logic signed [17:0]      raw_q;
	logic signed [17:0]      x_q;
	logic signed [17:0]      fb_q;
	logic signed [17:0]      v_q;
	logic [15:0]             v2_q;
	logic signed [17:0]      y_q;
	svoel_pkg::prod_t        acc_q;

	svoel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	svoel_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// ---------------- waveform ----------------
	logic [15:0]        u;
	logic [15:0]        u_sh;
	logic signed [15:0] saw16;
	logic signed [17:0] saw;
	logic signed [17:0] sq;
	logic signed [17:0] sq_sh;
	logic signed [17:0] mix_sum;
	logic signed [17:0] mix_b;
	logic signed [17:0] mix;
	logic signed [17:0] raw_c;

	assign u       = phase_q[PHASE_BITS-1 -: 16];
	assign u_sh    = u + 16'd16384;
	assign saw16   = {~u[15], u[14:0]};
	assign saw     = 18'(saw16);
	assign sq      = u[15] ? -18'sd32768 : 18'sd32768;
	assign sq_sh   = u_sh[15] ? -18'sd32768 : 18'sd32768;
	assign mix_sum = saw + sq_sh;
	assign mix_b   = mix_sum[17] ? 18'sd1 : 18'sd0;
	assign mix     = (mix_sum + mix_b) >>> 1;

	always_comb begin
		case (cfg.wave)
			WAVE_SAW:    raw_c = saw;
			WAVE_SQUARE: raw_c = sq;
			WAVE_MIX:    raw_c = mix;
			default:     raw_c = 18'sd0;
		endcase
	end

	// ---------------- operand selection ----------------
	logic signed [31:0] diff;
	logic [16:0]        a_c;
	logic [16:0]        inv_a;
	logic [16:0]        comp;
	logic signed [19:0] hp_in;
	logic signed [17:0] v_abs;
	logic [16:0]        shp;

	assign diff  = $signed({1'b0, tgt_q}) - $signed({1'b0, cur_q});
	assign a_c   = (cfg.cutoff > 16'd32768) ? 17'd32768 : {1'b0, cfg.cutoff};
	assign inv_a = 17'd65536 - a_c;
	assign comp  = 17'd16384 + {2'b00, cfg.reso[15:1]};
	assign hp_in = 20'(hps_q) + 20'(fb_q) - 20'(lfb_q);
	assign v_abs = v_q[17] ? -v_q : v_q;
	assign shp   = 17'd49152 - {2'b00, v2_q[15:1]};

	always_comb begin
		mreq.start = (state_q == ST_LOAD);
		case (op_q)
			OP_GLIDE: begin mreq.mcand = diff;                mreq.mier = {1'b0, glide_q}; end
			OP_DECAY: begin mreq.mcand = 32'(env_q);          mreq.mier = {1'b0, cfg.decay}; end
			OP_SUB:   begin mreq.mcand = 32'(raw_c);          mreq.mier = 17'd22938; end
			OP_ENV:   begin mreq.mcand = 32'(raw_q);          mreq.mier = env_q; end
			OP_FB:    begin mreq.mcand = 32'(pole_q[2]);      mreq.mier = {1'b0, cfg.reso}; end
			OP_HP:    begin mreq.mcand = 32'(hp_in);          mreq.mier = 17'd63570; end
			OP_COMP:  begin mreq.mcand = 32'(x_q);            mreq.mier = comp; end
			OP_SQ:    begin mreq.mcand = 32'(v_abs);          mreq.mier = v_abs[16:0]; end
			OP_SHAPE: begin mreq.mcand = 32'(v_q);            mreq.mier = shp; end
			OP_P0A:   begin mreq.mcand = 32'(y_q);            mreq.mier = a_c; end
			OP_P0B:   begin mreq.mcand = 32'(pole_q[0]);      mreq.mier = inv_a; end
			OP_P1A:   begin mreq.mcand = 32'(pole_q[0]);      mreq.mier = a_c; end
			OP_P1B:   begin mreq.mcand = 32'(pole_q[1]);      mreq.mier = inv_a; end
			OP_P2A:   begin mreq.mcand = 32'(pole_q[1]);      mreq.mier = a_c; end
			OP_P2B:   begin mreq.mcand = 32'(pole_q[2]);      mreq.mier = inv_a; end
			default:  begin mreq.mcand = 32'sd0;              mreq.mier = 17'd0; end
		endcase
	end

	// ---------------- result shaping ----------------
	svoel_pkg::prod_t p;
	svoel_pkg::prod_t q14;
	svoel_pkg::prod_t q15;
	svoel_pkg::prod_t q16;
	svoel_pkg::prod_t sub_t;
	svoel_pkg::prod_t sub_r;
	svoel_pkg::prod_t pole_n;
	svoel_pkg::prod_t v_pre;
	logic signed [17:0] hp_c;
	logic signed [17:0] v_c;
	logic [SUM_W-1:0]   sum;
	logic               wrap;
	logic [17:0]        e_sum;
	logic               wb;

	assign p      = mrsp.product;
	assign q14    = svoel_pkg::tdiv(p, 14);
	assign q15    = svoel_pkg::tdiv(p, 15);
	assign q16    = svoel_pkg::tdiv(p, 16);
	// Sub-octave square at 0.3 of full scale.
	assign sub_t  = p + (sub_q ? svoel_pkg::prod_t'(322109440) : -svoel_pkg::prod_t'(322109440));
	assign sub_r  = svoel_pkg::tdiv(sub_t, 15);
	assign pole_n = svoel_pkg::tdiv(acc_q + p, 16);
	assign v_pre  = q14 - svoel_pkg::prod_t'(hps_q);
	assign sum    = SUM_W'(phase_q) + SUM_W'(cur_q);
	assign wrap   = |sum[SUM_W-1:PHASE_BITS];
	assign e_sum  = 18'(env_q) + 18'(cfg.attack);
	assign wb     = (state_q == ST_WAIT) && mrsp.done;

	always_comb begin
		if (q16 > svoel_pkg::prod_t'(131071)) begin
			hp_c = 18'sd131071;
		end else if (q16 < -svoel_pkg::prod_t'(131072)) begin
			hp_c = -18'sd131072;
		end else begin
			hp_c = q16[17:0];
		end
		if (v_pre > svoel_pkg::prod_t'(32768)) begin
			v_c = 18'sd32768;
		end else if (v_pre < -svoel_pkg::prod_t'(32768)) begin
			v_c = -18'sd32768;
		end else begin
			v_c = v_pre[17:0];
		end
	end

	// ---------------- output scaling ----------------
	logic signed [OW-1:0] scaled;
	logic signed [OW-1:0] bias_o;
	logic signed [OW-1:0] os;
	logic signed [OW-1:0] os_c;

	assign scaled = OW'(pole_q[2]) <<< UP;
	assign bias_o = scaled[OW-1] ? DN_MASK : OW'(0);
	assign os     = (scaled + bias_o) >>> DN;
	assign os_c   = (os > SMAX) ? SMAX : ((os < SMIN) ? SMIN : os);

	// ---------------- sequencer and voice state ----------------
	logic emit_go;

	assign emit_go   = (state_q == ST_EMIT) && (!out_v_q || audio.ready);
	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_GLIDE;
			phase_q   <= '0;
			cur_q     <= '0;
			tgt_q     <= '0;
			glide_q   <= '0;
			env_q     <= '0;
			att_q     <= 1'b0;
			sub_q     <= 1'b0;
			pole_q[0] <= '0;
			pole_q[1] <= '0;
			pole_q[2] <= '0;
			hps_q     <= '0;
			lfb_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (emit_go) begin
				out_v_q <= 1'b1;
			end else if (audio.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						if (cmd.action) begin
							tgt_q   <= cmd.note_step;
							glide_q <= cmd.glide_rate;
							if (cmd.retrigger) begin
								env_q <= '0;
								att_q <= 1'b1;
							end
						end else begin
							op_q    <= OP_GLIDE;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (wb) begin
						case (op_q)
							OP_GLIDE: begin
								cur_q <= cur_q + q16[STEP_W-1:0];
								if (att_q) begin
									if (e_sum >= 18'd65536) begin
										env_q <= 17'd65536;
										att_q <= 1'b0;
									end else begin
										env_q <= e_sum[16:0];
									end
								end
							end
							OP_DECAY: begin
								phase_q <= sum[PHASE_BITS-1:0];
								if (wrap) begin
									sub_q <= ~sub_q;
								end
								if (!att_q) begin
									env_q <= q16[16:0];
								end
							end
							OP_HP: begin
								hps_q <= hp_c;
								lfb_q <= fb_q;
							end
							OP_P0B: pole_q[0] <= pole_n[17:0];
							OP_P1B: pole_q[1] <= pole_n[17:0];
							OP_P2B: pole_q[2] <= pole_n[17:0];
							default: begin
							end
						endcase
						if (op_q == OP_P2B) begin
							state_q <= ST_EMIT;
						end else begin
							op_q    <= op_t'(op_q + 4'd1);
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb) begin
			case (op_q)
				OP_SUB:   raw_q <= cfg.sub_en ? sub_r[17:0] : raw_c;
				OP_ENV:   x_q   <= q16[17:0];
				OP_FB:    fb_q  <= q14[17:0];
				OP_COMP:  v_q   <= v_c;
				OP_SQ:    v2_q  <= p[30:15];
				OP_SHAPE: y_q   <= q15[17:0];
				OP_P0A, OP_P1A, OP_P2A: acc_q <= p;
				default: begin
				end
			endcase
		end
		if (emit_go) begin
			sample_q <= os_c[SAMPLE_BITS-1:0];
		end
	end

	assign audio.valid  = out_v_q;
	assign audio.sample = sample_q;

`ifndef SYNTHESIS
	a_load_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !mrsp.busy)
		else $error("multiplier started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> (state_q == ST_WAIT))
		else $error("multiplier result outside wait step");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= 17'd65536)
		else $error("envelope above full scale");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_v_q && !audio.ready) |=> (state_q == ST_EMIT))
		else $error("sample overwrote a pending output");

	a_idle_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mrsp.busy)
		else $error("multiplier busy while idle");
`endif

endmodule
`default_nettype wire
